// ===== rtl/core/sdspi_pkg.sv =====
// Package for the SPI-mode SD card host: payload structs, request codes,
// phase codes and command bytes. No dependencies.
package sdspi_pkg;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] sector_address;
        logic [8:0]  read_offset;
        logic [9:0]  read_count;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       slow_clock;
        logic       rd_valid;
        logic [7:0] rd_byte;
        logic       done_res;
        logic [1:0] status;
        logic [2:0] card_kind;
    } out_item_t;

    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_WSTART = 3'd2;
    localparam logic [2:0] REQ_WBYTE  = 3'd3;
    localparam logic [2:0] REQ_WFIN   = 3'd4;
    localparam logic [2:0] REQ_CARD   = 3'd5;
    localparam logic [2:0] REQ_TICK   = 3'd6;

    localparam logic [2:0] CFG_RESP_POLL  = 3'd0;
    localparam logic [2:0] CFG_INIT_RETRY = 3'd1;
    localparam logic [2:0] CFG_TOKEN_TO   = 3'd2;
    localparam logic [2:0] CFG_BUSY_POLL  = 3'd3;
    localparam logic [2:0] CFG_RETRY_DLY  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERR   = 2'd1;
    localparam logic [1:0] ST_NOINIT = 2'd2;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_MMC  = 3'd1;
    localparam logic [2:0] KIND_SD1  = 3'd2;
    localparam logic [2:0] KIND_SD2B = 3'd3;
    localparam logic [2:0] KIND_SD2H = 3'd4;

    localparam logic [7:0] CMD0   = 8'h40;
    localparam logic [7:0] CMD1   = 8'h41;
    localparam logic [7:0] CMD8   = 8'h48;
    localparam logic [7:0] CMD16  = 8'h50;
    localparam logic [7:0] CMD17  = 8'h51;
    localparam logic [7:0] CMD24  = 8'h58;
    localparam logic [7:0] CMD55  = 8'h77;
    localparam logic [7:0] CMD58  = 8'h7A;
    localparam logic [7:0] ACMD41 = 8'hE9;

    localparam logic [7:0] TOKEN_START = 8'hFE;
    localparam logic [7:0] FILL_BYTE   = 8'hFF;

    typedef enum logic [4:0] {
        P_IDLE, P_RESET, P_CMD_FRAME, P_CMD_POLL, P_RETRY_WAIT,
        P_I_CMD0, P_I_CMD8, P_I_OCR8, P_I_LOOP, P_I_CMD58, P_I_OCR58,
        P_I_PROBE, P_I_CMD16, P_I_FINAL,
        P_R_CMD, P_R_TOKEN, P_R_DATA,
        P_W_CMD, P_W_GAP, P_W_TOKEN, P_W_BYTE,
        P_F_FILL, P_F_RESP, P_F_BUSY, P_BUSY_WAIT, P_FINAL
    } phase_t;

endpackage

// ===== rtl/core/sd_spi_host_controller_unit.sv =====
// Top level of the SPI-mode SD/MMC card host controller.
// Depends on sdspi_pkg and sdspi_frame.
//
//  channel | direction | payload        | handshake
//  s_      | in        | in_item_t      | s_valid / s_ready
//  m_      | out       | out_item_t     | m_valid / m_ready
//  cfg     | in        | index, data    | cfg_valid / cfg_ready
//
// Each item is handled by the combinational phase logic between the input
// and the result register; one item per cycle while results are taken.
// A full result register with a stalled consumer holds the input back.
// aresetn clears phase and counters and loads the default limits.
module sd_spi_host_controller_unit #(
    parameter int SECTOR_BYTES = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sdspi_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sdspi_pkg::out_item_t m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int CW = $clog2(SECTOR_BYTES + 3);

    logic [7:0]  resp_lim_reg;
    logic [15:0] retry_lim_reg, token_to_reg, busy_lim_reg, delay_reg;

    sdspi_pkg::phase_t phase_reg, phase_next, ret_reg, ret_next;
    logic [2:0]  kind_reg, kind_next, pend_reg, pend_next, fidx_reg, fidx_next;
    logic [31:0] arg_reg, arg_next, ocr_reg, ocr_next;
    logic [15:0] poll_reg, poll_next, retry_reg, retry_next, dly_reg, dly_next;
    logic [CW-1:0] bcnt_reg, bcnt_next, dleft_reg, dleft_next, wleft_reg, wleft_next;
    logic        wopen_reg, wopen_next, prefix_reg, prefix_next, initaft_reg, initaft_next;
    logic        cs_reg, cs_next, slow_reg, slow_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [1:0]  endst_reg, endst_next;

    logic        any, tx, rd, done;
    logic [7:0]  txb, rdb;
    logic [1:0]  st;
    logic [7:0]  fbyte;
    logic [2:0]  fidx_q;
    logic [31:0] addr;
    logic [15:0] poll_dec;
    logic [7:0]  b;

    sdspi_pkg::out_item_t res;
    logic        m_valid_reg;
    sdspi_pkg::out_item_t m_data_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign b         = s_data.data_byte;
    assign addr      = (kind_reg == sdspi_pkg::KIND_SD2H) ? s_data.sector_address
                                                          : {s_data.sector_address[22:0], 9'd0};
    assign fidx_q    = fidx_reg + 3'd1;
    assign poll_dec  = poll_reg - 16'd1;

    sdspi_frame u_frame (
        .idx(fidx_q), .prefix(prefix_reg), .cmd(cmd_reg), .arg(arg_reg),
        .frame_byte(fbyte)
    );

    // Step the phase machine on one accepted item
    always_comb begin
        phase_next = phase_reg; ret_next = ret_reg; kind_next = kind_reg;
        pend_next = pend_reg; fidx_next = fidx_reg; arg_next = arg_reg;
        ocr_next = ocr_reg; poll_next = poll_reg; retry_next = retry_reg;
        dly_next = dly_reg; bcnt_next = bcnt_reg; dleft_next = dleft_reg;
        wleft_next = wleft_reg; wopen_next = wopen_reg; prefix_next = prefix_reg;
        initaft_next = initaft_reg; cs_next = cs_reg; slow_next = slow_reg;
        cmd_next = cmd_reg; endst_next = endst_reg;
        tx = 1'b0; rd = 1'b0; done = 1'b0; txb = 8'd0; rdb = 8'd0; st = 2'd0;

        if (s_data.req_type == sdspi_pkg::REQ_CARD) begin
            case (phase_reg)
                sdspi_pkg::P_RESET: begin
                    bcnt_next = bcnt_reg + 1'b1;
                    if (bcnt_next < CW'(10)) begin
                        tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    end else begin
                        cmd_next = sdspi_pkg::CMD0; arg_next = 32'd0;
                        ret_next = sdspi_pkg::P_I_CMD0; prefix_next = 1'b0;
                        fidx_next = 3'd0; cs_next = 1'b0; tx = 1'b1;
                        txb = sdspi_pkg::FILL_BYTE; phase_next = sdspi_pkg::P_CMD_FRAME;
                    end
                end
                sdspi_pkg::P_CMD_FRAME: begin
                    tx = 1'b1;
                    if (fidx_reg < 3'd7) begin
                        fidx_next = fidx_q;
                        if (fidx_q == 3'd1) cs_next = 1'b1;
                        txb = fbyte;
                    end else begin
                        poll_next = {8'd0, resp_lim_reg};
                        txb = sdspi_pkg::FILL_BYTE; phase_next = sdspi_pkg::P_CMD_POLL;
                    end
                end
                sdspi_pkg::P_CMD_POLL: begin
                    if (b[7] && poll_dec[7:0] != 8'd0) begin
                        poll_next = {8'd0, poll_dec[7:0]};
                        tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    end else if (prefix_reg && b <= 8'd1) begin
                        prefix_next = 1'b0; fidx_next = 3'd0; cs_next = 1'b0;
                        tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                        phase_next = sdspi_pkg::P_CMD_FRAME;
                    end else begin
                        // Response handling for the command's return phase
                        phase_next = ret_reg;
                        case (ret_reg)
                            sdspi_pkg::P_I_CMD0: begin
                                if (b == 8'd1) begin
                                    cmd_next = sdspi_pkg::CMD8; arg_next = 32'h1AA;
                                    ret_next = sdspi_pkg::P_I_CMD8;
                                    prefix_next = 1'b0; fidx_next = 3'd0; cs_next = 1'b0;
                                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                    phase_next = sdspi_pkg::P_CMD_FRAME;
                                end else begin
                                    pend_next = sdspi_pkg::KIND_NONE; cs_next = 1'b0;
                                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                    phase_next = sdspi_pkg::P_I_FINAL;
                                end
                            end
                            sdspi_pkg::P_I_CMD8: begin
                                tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                if (b == 8'd1) begin
                                    bcnt_next = '0; phase_next = sdspi_pkg::P_I_OCR8;
                                end else begin
                                    cmd_next = sdspi_pkg::ACMD41; arg_next = 32'd0;
                                    ret_next = sdspi_pkg::P_I_PROBE;
                                    prefix_next = 1'b1; fidx_next = 3'd0; cs_next = 1'b0;
                                    phase_next = sdspi_pkg::P_CMD_FRAME;
                                end
                            end
                            sdspi_pkg::P_I_PROBE: begin
                                pend_next = (b <= 8'd1) ? sdspi_pkg::KIND_SD1
                                                        : sdspi_pkg::KIND_MMC;
                                retry_next = retry_lim_reg;
                                cmd_next = (b <= 8'd1) ? sdspi_pkg::ACMD41 : sdspi_pkg::CMD1;
                                arg_next = 32'd0; ret_next = sdspi_pkg::P_I_LOOP;
                                prefix_next = (b <= 8'd1); fidx_next = 3'd0; cs_next = 1'b0;
                                tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                phase_next = sdspi_pkg::P_CMD_FRAME;
                            end
                            sdspi_pkg::P_I_LOOP: begin
                                if (b != 8'd0 && retry_reg != 16'd0) begin
                                    retry_next = retry_reg - 16'd1;
                                    if (delay_reg == 16'd0) begin
                                        prefix_next = cmd_reg[7]; fidx_next = 3'd0;
                                        cs_next = 1'b0; tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                        phase_next = sdspi_pkg::P_CMD_FRAME;
                                    end else begin
                                        dly_next = delay_reg;
                                        phase_next = sdspi_pkg::P_RETRY_WAIT;
                                    end
                                end else if (b != 8'd0 || retry_reg == 16'd0) begin
                                    pend_next = sdspi_pkg::KIND_NONE; cs_next = 1'b0;
                                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                    phase_next = sdspi_pkg::P_I_FINAL;
                                end else begin
                                    if (pend_reg == sdspi_pkg::KIND_SD2B) begin
                                        cmd_next = sdspi_pkg::CMD58; arg_next = 32'd0;
                                        ret_next = sdspi_pkg::P_I_CMD58;
                                    end else begin
                                        cmd_next = sdspi_pkg::CMD16;
                                        arg_next = 32'(SECTOR_BYTES);
                                        ret_next = sdspi_pkg::P_I_CMD16;
                                    end
                                    prefix_next = 1'b0; fidx_next = 3'd0; cs_next = 1'b0;
                                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                    phase_next = sdspi_pkg::P_CMD_FRAME;
                                end
                            end
                            sdspi_pkg::P_I_CMD58: begin
                                tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                if (b == 8'd0) begin
                                    bcnt_next = '0; phase_next = sdspi_pkg::P_I_OCR58;
                                end else begin
                                    pend_next = sdspi_pkg::KIND_NONE; cs_next = 1'b0;
                                    phase_next = sdspi_pkg::P_I_FINAL;
                                end
                            end
                            sdspi_pkg::P_I_CMD16: begin
                                pend_next = (b == 8'd0) ? pend_reg : sdspi_pkg::KIND_NONE;
                                cs_next = 1'b0; tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                phase_next = sdspi_pkg::P_I_FINAL;
                            end
                            sdspi_pkg::P_R_CMD: begin
                                tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                if (b == 8'd0) begin
                                    poll_next = token_to_reg;
                                    phase_next = sdspi_pkg::P_R_TOKEN;
                                end else begin
                                    endst_next = sdspi_pkg::ST_ERR; cs_next = 1'b0;
                                    phase_next = sdspi_pkg::P_FINAL;
                                end
                            end
                            sdspi_pkg::P_W_CMD: begin
                                if (b == 8'd0) begin
                                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                                    phase_next = sdspi_pkg::P_W_GAP;
                                end else begin
                                    done = 1'b1; st = sdspi_pkg::ST_ERR;
                                    phase_next = sdspi_pkg::P_IDLE;
                                end
                            end
                            default: phase_next = sdspi_pkg::P_IDLE;
                        endcase
                    end
                end
                sdspi_pkg::P_I_OCR8, sdspi_pkg::P_I_OCR58: begin
                    ocr_next = {ocr_reg[23:0], b};
                    bcnt_next = bcnt_reg + 1'b1;
                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    if (bcnt_next < CW'(4)) begin
                    end else if (phase_reg == sdspi_pkg::P_I_OCR58) begin
                        pend_next = ocr_next[30] ? sdspi_pkg::KIND_SD2H : sdspi_pkg::KIND_SD2B;
                        cs_next = 1'b0; phase_next = sdspi_pkg::P_I_FINAL;
                    end else if (ocr_next[15:0] == 16'h01AA) begin
                        pend_next = sdspi_pkg::KIND_SD2B; retry_next = retry_lim_reg;
                        cmd_next = sdspi_pkg::ACMD41; arg_next = 32'h4000_0000;
                        ret_next = sdspi_pkg::P_I_LOOP; prefix_next = 1'b1;
                        fidx_next = 3'd0; cs_next = 1'b0;
                        phase_next = sdspi_pkg::P_CMD_FRAME;
                    end else begin
                        pend_next = sdspi_pkg::KIND_NONE; cs_next = 1'b0;
                        phase_next = sdspi_pkg::P_I_FINAL;
                    end
                end
                sdspi_pkg::P_I_FINAL: begin
                    kind_next = pend_reg;
                    if (pend_reg != sdspi_pkg::KIND_NONE) slow_next = 1'b0;
                    done = 1'b1;
                    st = (pend_reg != sdspi_pkg::KIND_NONE) ? sdspi_pkg::ST_OK
                                                            : sdspi_pkg::ST_NOINIT;
                    phase_next = sdspi_pkg::P_IDLE;
                end
                sdspi_pkg::P_R_TOKEN: begin
                    if (b == 8'hFF && poll_dec != 16'd0) begin
                        poll_next = poll_dec; tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    end else begin
                        if (b == 8'hFF) poll_next = poll_dec;
                        tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                        if (b == sdspi_pkg::TOKEN_START) begin
                            poll_next = 16'(SECTOR_BYTES + 2);
                            phase_next = sdspi_pkg::P_R_DATA;
                        end else begin
                            endst_next = sdspi_pkg::ST_ERR; cs_next = 1'b0;
                            phase_next = sdspi_pkg::P_FINAL;
                        end
                    end
                end
                sdspi_pkg::P_R_DATA: begin
                    if (bcnt_reg != '0) bcnt_next = bcnt_reg - 1'b1;
                    else if (dleft_reg != '0) begin
                        rd = 1'b1; rdb = b; dleft_next = dleft_reg - 1'b1;
                    end
                    poll_next = poll_dec;
                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    if (poll_dec == 16'd0) begin
                        endst_next = sdspi_pkg::ST_OK; cs_next = 1'b0;
                        phase_next = sdspi_pkg::P_FINAL;
                    end
                end
                sdspi_pkg::P_W_GAP: begin
                    tx = 1'b1; txb = sdspi_pkg::TOKEN_START;
                    phase_next = sdspi_pkg::P_W_TOKEN;
                end
                sdspi_pkg::P_W_TOKEN: begin
                    wleft_next = CW'(SECTOR_BYTES); wopen_next = 1'b1;
                    done = 1'b1; st = sdspi_pkg::ST_OK; phase_next = sdspi_pkg::P_IDLE;
                end
                sdspi_pkg::P_W_BYTE: begin
                    done = 1'b1; st = sdspi_pkg::ST_OK; phase_next = sdspi_pkg::P_IDLE;
                end
                sdspi_pkg::P_F_FILL: begin
                    tx = 1'b1;
                    if (bcnt_reg != '0) begin
                        bcnt_next = bcnt_reg - 1'b1; txb = 8'h00;
                    end else begin
                        txb = sdspi_pkg::FILL_BYTE; phase_next = sdspi_pkg::P_F_RESP;
                    end
                end
                sdspi_pkg::P_F_RESP: begin
                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    if (b[4:0] == 5'h05) begin
                        poll_next = busy_lim_reg; phase_next = sdspi_pkg::P_F_BUSY;
                    end else begin
                        endst_next = sdspi_pkg::ST_ERR; cs_next = 1'b0;
                        phase_next = sdspi_pkg::P_FINAL;
                    end
                end
                sdspi_pkg::P_F_BUSY: begin
                    if (b != 8'hFF && poll_reg != 16'd0) begin
                        poll_next = poll_dec;
                        if (delay_reg == 16'd0) begin
                            tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                        end else begin
                            dly_next = delay_reg; phase_next = sdspi_pkg::P_BUSY_WAIT;
                        end
                    end else begin
                        endst_next = (poll_reg != 16'd0) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_ERR;
                        cs_next = 1'b0; tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                        phase_next = sdspi_pkg::P_FINAL;
                    end
                end
                sdspi_pkg::P_FINAL: begin
                    if (initaft_reg) begin
                        initaft_next = 1'b0; cs_next = 1'b0; slow_next = 1'b1;
                        bcnt_next = '0; tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                        phase_next = sdspi_pkg::P_RESET;
                    end else begin
                        done = 1'b1; st = endst_reg; phase_next = sdspi_pkg::P_IDLE;
                    end
                end
                default: ;
            endcase
        end else if (s_data.req_type == sdspi_pkg::REQ_TICK) begin
            if (phase_reg == sdspi_pkg::P_RETRY_WAIT || phase_reg == sdspi_pkg::P_BUSY_WAIT) begin
                dly_next = dly_reg - 16'd1;
                if (dly_next == 16'd0) begin
                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    if (phase_reg == sdspi_pkg::P_RETRY_WAIT) begin
                        prefix_next = cmd_reg[7]; fidx_next = 3'd0; cs_next = 1'b0;
                        phase_next = sdspi_pkg::P_CMD_FRAME;
                    end else begin
                        phase_next = sdspi_pkg::P_F_BUSY;
                    end
                end
            end
        end else if (phase_reg == sdspi_pkg::P_IDLE) begin
            case (s_data.req_type)
                sdspi_pkg::REQ_INIT: begin
                    tx = 1'b1; cs_next = 1'b0;
                    if (kind_reg != sdspi_pkg::KIND_NONE && wopen_reg) begin
                        initaft_next = 1'b1; bcnt_next = wleft_reg + 1'b1;
                        wleft_next = '0; wopen_next = 1'b0; txb = 8'h00;
                        cs_next = cs_reg; phase_next = sdspi_pkg::P_F_FILL;
                    end else begin
                        slow_next = 1'b1; bcnt_next = '0;
                        txb = sdspi_pkg::FILL_BYTE; phase_next = sdspi_pkg::P_RESET;
                    end
                end
                sdspi_pkg::REQ_READ: begin
                    if (s_data.read_count == 10'd0 ||
                        ({2'b0, s_data.read_offset} + {1'b0, s_data.read_count})
                            > 11'(SECTOR_BYTES)) begin
                        done = 1'b1; st = sdspi_pkg::ST_ERR;
                    end else begin
                        bcnt_next = CW'(s_data.read_offset);
                        dleft_next = CW'(s_data.read_count);
                        cmd_next = sdspi_pkg::CMD17; arg_next = addr;
                        ret_next = sdspi_pkg::P_R_CMD; prefix_next = 1'b0;
                        fidx_next = 3'd0; cs_next = 1'b0;
                        tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                        phase_next = sdspi_pkg::P_CMD_FRAME;
                    end
                end
                sdspi_pkg::REQ_WSTART: begin
                    cmd_next = sdspi_pkg::CMD24; arg_next = addr;
                    ret_next = sdspi_pkg::P_W_CMD; prefix_next = 1'b0;
                    fidx_next = 3'd0; cs_next = 1'b0;
                    tx = 1'b1; txb = sdspi_pkg::FILL_BYTE;
                    phase_next = sdspi_pkg::P_CMD_FRAME;
                end
                sdspi_pkg::REQ_WBYTE: begin
                    if (wleft_reg != '0) begin
                        wleft_next = wleft_reg - 1'b1; tx = 1'b1; txb = s_data.data_byte;
                        phase_next = sdspi_pkg::P_W_BYTE;
                    end else begin
                        done = 1'b1; st = sdspi_pkg::ST_OK;
                    end
                end
                sdspi_pkg::REQ_WFIN: begin
                    initaft_next = 1'b0; bcnt_next = wleft_reg + 1'b1;
                    wleft_next = '0; wopen_next = 1'b0;
                    tx = 1'b1; txb = 8'h00; phase_next = sdspi_pkg::P_F_FILL;
                end
                default: ;
            endcase
        end

        if (done) phase_next = sdspi_pkg::P_IDLE;
        any = tx | rd | done;
        res.tx_valid = tx;  res.tx_byte = txb;
        res.cs_active = cs_next; res.slow_clock = slow_next;
        res.rd_valid = rd;  res.rd_byte = rdb;
        res.done_res = done; res.status = st;
        res.card_kind = kind_next;
    end

    // Hold limits, state and the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resp_lim_reg <= 8'd10; retry_lim_reg <= 16'd10000;
            token_to_reg <= 16'd40000; busy_lim_reg <= 16'd5000; delay_reg <= 16'd100;
            phase_reg <= sdspi_pkg::P_IDLE; ret_reg <= sdspi_pkg::P_IDLE;
            kind_reg <= '0; pend_reg <= '0; fidx_reg <= '0;
            arg_reg <= '0; ocr_reg <= '0; poll_reg <= '0; retry_reg <= '0;
            dly_reg <= '0; bcnt_reg <= '0; dleft_reg <= '0; wleft_reg <= '0;
            wopen_reg <= 1'b0; prefix_reg <= 1'b0; initaft_reg <= 1'b0;
            cs_reg <= 1'b0; slow_reg <= 1'b1; cmd_reg <= '0; endst_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    sdspi_pkg::CFG_RESP_POLL:  resp_lim_reg  <= cfg_data[7:0];
                    sdspi_pkg::CFG_INIT_RETRY: retry_lim_reg <= cfg_data[15:0];
                    sdspi_pkg::CFG_TOKEN_TO:   token_to_reg  <= cfg_data[15:0];
                    sdspi_pkg::CFG_BUSY_POLL:  busy_lim_reg  <= cfg_data[15:0];
                    sdspi_pkg::CFG_RETRY_DLY:  delay_reg     <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (s_valid && s_ready) begin
                phase_reg <= phase_next; ret_reg <= ret_next; kind_reg <= kind_next;
                pend_reg <= pend_next; fidx_reg <= fidx_next; arg_reg <= arg_next;
                ocr_reg <= ocr_next; poll_reg <= poll_next; retry_reg <= retry_next;
                dly_reg <= dly_next; bcnt_reg <= bcnt_next; dleft_reg <= dleft_next;
                wleft_reg <= wleft_next; wopen_reg <= wopen_next;
                prefix_reg <= prefix_next; initaft_reg <= initaft_next;
                cs_reg <= cs_next; slow_reg <= slow_next; cmd_reg <= cmd_next;
                endst_reg <= endst_next;
                if (any) m_valid_reg <= 1'b1;
            end
        end
    end

    // Capture the result payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && any) m_data_reg <= res;
    end

endmodule

// ===== rtl/core/sdspi_frame.sv =====
// Command frame byte generator: picks byte i of a command frame.
// Depends on sdspi_pkg.
module sdspi_frame (
    input  logic [2:0]  idx,
    input  logic        prefix,
    input  logic [7:0]  cmd,
    input  logic [31:0] arg,
    output logic [7:0]  frame_byte
);

    logic [7:0]  code;
    logic [31:0] a;

    // Select the byte: fill, command, argument MSB first, then CRC
    always_comb begin
        code = prefix ? sdspi_pkg::CMD55 : {1'b0, cmd[6:0]};
        a    = prefix ? 32'd0 : arg;
        case (idx)
            3'd0, 3'd1: frame_byte = sdspi_pkg::FILL_BYTE;
            3'd2:       frame_byte = code;
            3'd3:       frame_byte = a[31:24];
            3'd4:       frame_byte = a[23:16];
            3'd5:       frame_byte = a[15:8];
            3'd6:       frame_byte = a[7:0];
            default: begin
                if (code == sdspi_pkg::CMD0)      frame_byte = 8'h95;
                else if (code == sdspi_pkg::CMD8) frame_byte = 8'h87;
                else                               frame_byte = 8'h01;
            end
        endcase
    end

endmodule
